FILE: rtl/core/window_stability_calibrator_assert.svh
// Assertion macros for the window stability calibrator.
`ifndef WINDOW_STABILITY_CALIBRATOR_ASSERT_SVH
`define WINDOW_STABILITY_CALIBRATOR_ASSERT_SVH

`ifndef SYNTHESIS

// cond must never hold at a clock edge outside reset
`define WSC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// ante at an edge requires cons at the same edge
`define WSC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge requires cons at the next edge
`define WSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WSC_ASSERT_NEVER(label, cond, msg)
`define WSC_ASSERT_IMPLY(label, ante, cons, msg)
`define WSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/core/wsc_pkg.sv
// Constants and pipeline types of the window stability calibrator.
package wsc_pkg;

    localparam int NCHAN   = 3;
    localparam int WINDOW  = 10;
    localparam int DATA_W  = 12;
    localparam int CH_W    = 2;
    localparam int FULL    = 4095;
    localparam int TOL_RST = 2;

    localparam int RD_W   = 40;   // input tdata width
    localparam int OD_W   = 32;   // output tdata width

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DEPTH  = NCHAN * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = $clog2(WINDOW * FULL + 1);

    // level: floor(s / 3) as (s * ceil(2^16 / 3)) >> 16, exact for s < 2^14
    localparam int LSUM_W     = DATA_W + 2;
    localparam int LVL_SHIFT  = 16;
    localparam int LVL_RECIP  = (2 ** LVL_SHIFT + 2) / 3;
    localparam int LPROD_W    = LSUM_W + LVL_SHIFT;

    // mean: floor(sum / WINDOW) by round-up reciprocal, exact for sum < 2^SUM_W
    localparam int MEAN_SHIFT = SUM_W + PTR_W;
    localparam int MEAN_RECIP = (2 ** MEAN_SHIFT + WINDOW - 1) / WINDOW;
    localparam int MPROD_W    = SUM_W + MEAN_SHIFT;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic              clr;
        logic              smp;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] lvl;
        logic [ADDR_W-1:0] addr;
        logic              old_vld;
    } t_s1;

    typedef struct packed {
        logic              clr;
        logic              smp;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] lvl;
        logic [SUM_W-1:0]  sum;
    } t_s2;

    typedef struct packed {
        logic              clr;
        logic              smp;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] lvl;
        logic [DATA_W-1:0] mean;
    } t_s3;

endpackage

FILE: rtl/core/window_stability_calibrator.sv
// Top level of the window stability calibrator: level, ring update, mean, stability.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser: action, channel; tdata: readings a, b, c
//  m_axis    out  tvalid/tready           tuser: out_channel; tdata: level, mean, flags
//  cfg       in   valid/ready (ready=1)   data: tolerance
//
// One item per cycle while m_axis does not stall; a taken request passes the stage 1, 2, 3 and output registers.
// The rate is set by the ring RAM: one read at accept, the write back as the item leaves stage 1.
// Reset clears the ring valid bits, sums, pointers and flags at once; no clearing pass.
// A stalled output backs up through three internal stages before s_axis_tready drops.
module window_stability_calibrator
    import wsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DATA_W-1:0]   i_cfg_data,    // tolerance

    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [RD_W-1:0]     i_s_axis_tdata,  // reading_a, reading_b, reading_c, pad
    input  logic [2:0]          i_s_axis_tuser,  // action, channel

    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OD_W-1:0]     o_m_axis_tdata,  // level, window_mean, channel_stable,
                                                 // all_stable, pad
    output logic [CH_W-1:0]     o_m_axis_tuser   // out_channel
);

    // ------------------------------------------------------------------
    // registers
    logic [DATA_W-1:0] r_tol;
    logic [PTR_W-1:0]  r_wptr    [NCHAN];
    logic [SUM_W-1:0]  r_sum     [NCHAN];
    logic [NCHAN-1:0]  r_flags;
    logic [DEPTH-1:0]  r_ring_vld;

    logic r_s1_v, r_s2_v, r_s3_v, r_o_valid;
    t_s1  r_s1;
    t_s2  r_s2;
    t_s3  r_s3;
    logic [CH_W-1:0]   r_o_ch;
    logic [DATA_W-1:0] r_o_lvl;
    logic [DATA_W-1:0] r_o_mean;
    logic              r_o_st;
    logic              r_o_all;

    // ------------------------------------------------------------------
    // flow control
    logic en_out, en3, en2, en1, acc;
    logic s1_mv, s3_mv;

    assign en_out = !r_o_valid || i_m_axis_tready;
    assign en3    = !r_s3_v || en_out;
    assign en2    = !r_s2_v || en3;
    assign en1    = !r_s1_v || en2;
    assign acc    = i_s_axis_tvalid && en1;
    assign s1_mv  = r_s1_v && en2;
    assign s3_mv  = r_s3_v && en_out;

    assign o_s_axis_tready = en1;
    assign o_cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // accept stage: level and ring read address
    logic              in_act;
    logic [CH_W-1:0]   in_ch;
    logic              in_clr, in_smp;
    logic [LSUM_W-1:0] lsum;
    logic [LPROD_W-1:0] lprod;
    logic [DATA_W-1:0] in_lvl;
    logic [PTR_W-1:0]  ptr_sel;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    always_comb begin
        in_act  = i_s_axis_tuser[0];
        in_ch   = i_s_axis_tuser[2:1];
        in_clr  = (in_act == ACT_CLEAR);
        in_smp  = (in_act == ACT_SAMPLE) && (in_ch < CH_W'(NCHAN));
        // 4095 - x is the bitwise complement of a 12-bit value
        lsum    = {(LSUM_W - DATA_W)'(0), ~i_s_axis_tdata[DATA_W-1:0]}
                + {(LSUM_W - DATA_W)'(0), ~i_s_axis_tdata[2*DATA_W-1:DATA_W]}
                + {(LSUM_W - DATA_W)'(0), ~i_s_axis_tdata[3*DATA_W-1:2*DATA_W]};
        lprod   = LPROD_W'(lsum) * LPROD_W'(LVL_RECIP);
        in_lvl  = lprod[LVL_SHIFT +: DATA_W];
        ptr_sel = in_smp ? r_wptr[in_ch] : '0;
        rd_addr = (in_smp ? ADDR_W'(in_ch) : '0) * ADDR_W'(WINDOW) + ADDR_W'(ptr_sel);
        rd_en   = acc && in_smp;
    end

    // ------------------------------------------------------------------
    // stage 1: read-modify-write of the ring entry and the channel sum
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] old_val;
    logic [SUM_W-1:0]  sum_cur, sum_new;
    logic              ring_we;

    always_comb begin
        old_val = r_s1.old_vld ? ram_rdata : '0;
        sum_cur = r_s1.smp ? r_sum[r_s1.ch] : '0;
        sum_new = sum_cur + SUM_W'(r_s1.lvl) - SUM_W'(old_val);
        ring_we = s1_mv && r_s1.smp;
    end

    wsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.lvl),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 2: window mean by reciprocal multiply
    logic [MPROD_W-1:0] mprod;
    logic [DATA_W-1:0]  mean_val;

    always_comb begin
        mprod    = MPROD_W'(r_s2.sum) * MPROD_W'(MEAN_RECIP);
        mean_val = mprod[MEAN_SHIFT +: DATA_W];
    end

    // ------------------------------------------------------------------
    // stage 3: stability decision and flag update
    logic [DATA_W-1:0] diff;
    logic              st;
    logic [NCHAN-1:0]  flags_upd;

    always_comb begin
        diff      = (r_s3.mean >= r_s3.lvl) ? (r_s3.mean - r_s3.lvl)
                                            : (r_s3.lvl - r_s3.mean);
        st        = diff < r_tol;
        flags_upd = r_flags;
        if (r_s3.smp) begin
            flags_upd[r_s3.ch] = st;
        end
    end

    // ------------------------------------------------------------------
    // next state of the per-channel control
    logic [PTR_W-1:0] n_wptr     [NCHAN];
    logic [SUM_W-1:0] n_sum      [NCHAN];
    logic [DEPTH-1:0] n_ring_vld;
    logic [NCHAN-1:0] n_flags;

    always_comb begin
        for (int c = 0; c < NCHAN; c++) begin
            n_wptr[c] = r_wptr[c];
            n_sum[c]  = r_sum[c];
        end
        n_ring_vld = r_ring_vld;
        n_flags    = r_flags;

        if (acc && in_smp) begin
            n_wptr[in_ch] = (r_wptr[in_ch] == PTR_W'(WINDOW - 1)) ? '0
                                                                  : r_wptr[in_ch] + 1'b1;
        end
        if (ring_we) begin
            n_sum[r_s1.ch]        = sum_new;
            n_ring_vld[r_s1.addr] = 1'b1;
        end
        // a clear taken now wins over the write back of the item ahead of it
        if (acc && in_clr) begin
            for (int c = 0; c < NCHAN; c++) begin
                n_wptr[c] = '0;
                n_sum[c]  = '0;
            end
            n_ring_vld = '0;
        end

        if (s3_mv) begin
            n_flags = r_s3.clr ? '0 : flags_upd;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= DATA_W'(TOL_RST);
            r_ring_vld <= '0;
            r_flags    <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int c = 0; c < NCHAN; c++) begin
                r_wptr[c] <= '0;
                r_sum[c]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            r_ring_vld <= n_ring_vld;
            r_flags    <= n_flags;
            for (int c = 0; c < NCHAN; c++) begin
                r_wptr[c] <= n_wptr[c];
                r_sum[c]  <= n_sum[c];
            end
            if (en1) begin
                r_s1_v <= acc;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en_out) begin
                r_o_valid <= r_s3_v;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1.clr     <= in_clr;
            r_s1.smp     <= in_smp;
            r_s1.ch      <= in_ch;
            r_s1.lvl     <= in_lvl;
            r_s1.addr    <= rd_addr;
            r_s1.old_vld <= r_ring_vld[rd_addr];
        end
        if (en2) begin
            r_s2.clr <= r_s1.clr;
            r_s2.smp <= r_s1.smp;
            r_s2.ch  <= r_s1.ch;
            r_s2.lvl <= r_s1.lvl;
            r_s2.sum <= sum_new;
        end
        if (en3) begin
            r_s3.clr  <= r_s2.clr;
            r_s3.smp  <= r_s2.smp;
            r_s3.ch   <= r_s2.ch;
            r_s3.lvl  <= r_s2.lvl;
            r_s3.mean <= mean_val;
        end
        if (en_out) begin
            if (r_s3.clr) begin
                r_o_ch   <= '0;
                r_o_lvl  <= '0;
                r_o_mean <= '0;
                r_o_st   <= 1'b0;
                r_o_all  <= 1'b0;
            end else begin
                r_o_ch   <= r_s3.ch;
                r_o_lvl  <= r_s3.lvl;
                r_o_mean <= r_s3.smp ? r_s3.mean : '0;
                r_o_st   <= r_s3.smp && st;
                r_o_all  <= &flags_upd;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_ch;
    assign o_m_axis_tdata  = {(OD_W - 2 * DATA_W - 2)'(0), r_o_all, r_o_st, r_o_mean, r_o_lvl};

    // ------------------------------------------------------------------
    // assertions
    `include "window_stability_calibrator_assert.svh"

    `WSC_ASSERT_IMPLY(a_ring_no_collision, ring_we && rd_en, r_s1.addr != rd_addr,
                      "ring read and write back hit the same entry")
    `WSC_ASSERT_NEXT(a_ring_marked, ring_we && !(acc && in_clr),
                     r_ring_vld[$past(r_s1.addr)], "written ring entry not marked valid")
    `WSC_ASSERT_NEXT(a_clear_wipes, acc && in_clr,
                     r_ring_vld == '0 && r_wptr[0] == '0 && r_sum[0] == '0,
                     "clear request left ring state behind")

endmodule

FILE: rtl/core/wsc_ram.sv
// Generic simple dual-port RAM with registered read.
module wsc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
